### hdl/assert_macros.svh
// Assertion helper macros for the PWM serializer RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: lbl");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/mcps_pkg.sv
// Shared types and constants for the multi-channel PWM serializer.
// No dependencies.
`default_nettype none

package mcps_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PAT_W    = 8;
  localparam int POS_W    = 3;

  localparam logic [7:0] TOP_RESET = 8'd100;
  localparam logic [POS_W-1:0] POS_FIRST = 3'd7;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd0;

  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // pattern queue between front and back; depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       mode;
    logic [7:0] channel;
    logic [7:0] duty;
  } in_item_t;

  typedef struct packed {
    logic             serial_bit;
    logic [POS_W-1:0] bit_position;
    logic [PAT_W-1:0] pattern;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### hdl/mcps_front.sv
// Front end: duty writes, period stepping and pattern update per tick.
// Depends on mcps_pkg.
`default_nettype none

module mcps_front
  import mcps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             req_valid,
  input  wire in_item_t         req,
  input  wire q_status_t        q_stat,
  output logic                  req_ready,
  output logic                  q_push,
  output logic [PAT_W-1:0]      q_data
);

  logic [7:0]       top_r;
  logic [7:0]       step_r, step_nxt;
  logic [PAT_W-1:0] pattern_r, pattern_nxt;
  logic [PAT_W-1:0] mask_r;
  logic [7:0]       active_r  [CHANNELS];
  logic [7:0]       pending_r [CHANNELS];

  logic             accept, is_tick, is_set, reload;
  logic [PAT_W-1:0] clr_mask;
  logic [CH_W-1:0]  ch_idx;

  assign req_ready = !q_stat.full;
  assign accept    = req_valid && req_ready;
  assign is_tick   = accept && (req.mode == MODE_TICK);
  assign is_set    = accept && (req.mode == MODE_SET) && (req.channel < 8'(CHANNELS));
  assign ch_idx    = req.channel[CH_W-1:0];
  assign reload    = (step_r == top_r);

  always_comb begin
    clr_mask = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (step_r == active_r[k]) clr_mask[k] = 1'b1;
    end
    pattern_nxt = reload ? mask_r : (pattern_r & ~clr_mask);
    step_nxt    = reload ? 8'd1 : step_r + 8'd1;
  end

  assign q_push = is_tick;
  assign q_data = pattern_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= TOP_RESET;
      step_r    <= '0;
      pattern_r <= '0;
      mask_r    <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        active_r[k]  <= '0;
        pending_r[k] <= '0;
      end
    end else begin
      if (cfg_we) top_r <= cfg_data;
      if (is_set) begin
        pending_r[ch_idx] <= req.duty;
        mask_r[ch_idx]    <= (req.duty != 8'd0);
      end
      if (is_tick) begin
        step_r    <= step_nxt;
        pattern_r <= pattern_nxt;
        if (reload) begin
          for (int k = 0; k < CHANNELS; k++) active_r[k] <= pending_r[k];
        end
      end
    end
  end

  `include "assert_macros.svh"

  // a reload restarts the period at step one
  `ASSERT_NEXT(a_reload_step, clk, rst_n, is_tick && reload, step_r == 8'd1)
  // a duty write never touches the step counter
  `ASSERT_NEXT(a_set_keeps_step, clk, rst_n, accept && !is_tick && !cfg_we,
               $stable(step_r) && $stable(pattern_r))

endmodule

`default_nettype wire

### hdl/mcps_queue.sv
// Short pattern queue that decouples the front end from the serializer.
// Depends on mcps_pkg.
`default_nettype none

module mcps_queue
  import mcps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [PAT_W-1:0] wr_data,
  input  wire logic             pop,
  output logic [PAT_W-1:0]      rd_data,
  output q_status_t             stat
);

  logic [PAT_W-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH))
  // fill level tracks the pointer distance
  `ASSERT_ALWAYS(a_ptr_cnt, clk, rst_n,
                 QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])

endmodule

`default_nettype wire

### hdl/mcps_back.sv
// Back end: shifts each queued pattern out as eight results, MSB first.
// Depends on mcps_pkg.
`default_nettype none

module mcps_back
  import mcps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire q_status_t        q_stat,
  input  wire logic [PAT_W-1:0] q_data,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output out_item_t             out_data
);

  logic             valid_r;
  logic [PAT_W-1:0] pattern_r;
  logic [POS_W-1:0] pos_r;
  logic             taken, load;

  assign taken = out_pop && valid_r;
  assign load  = !q_stat.empty && (!valid_r || (taken && pos_r == POS_LAST));
  assign q_pop = load;

  assign out_empty             = !valid_r;
  assign out_data.serial_bit   = pattern_r[pos_r];
  assign out_data.bit_position = pos_r;
  assign out_data.pattern      = pattern_r;
  assign out_data.last         = (pos_r == POS_LAST);

  always_ff @(posedge clk) begin
    if (load) pattern_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= POS_FIRST;
    end else if (load) begin
      valid_r <= 1'b1;
      pos_r   <= POS_FIRST;
    end else if (taken) begin
      if (pos_r == POS_LAST) valid_r <= 1'b0;
      else pos_r <= pos_r - 1'b1;
    end
  end

  `include "assert_macros.svh"

  // mid-pattern request steps one bit down without reloading
  `ASSERT_NEXT(a_pos_step, clk, rst_n, taken && pos_r != POS_LAST,
               valid_r && pos_r == $past(pos_r) - 1'b1 && $stable(pattern_r))

endmodule

`default_nettype wire

### hdl/multi_channel_pwm_serializer.sv
// Top level of the eight-channel PWM serializer.
// Depends on mcps_pkg, mcps_front, mcps_queue and mcps_back.
`default_nettype none

// Eight-channel PWM with double-buffered duties, serialized for an external
// shift register with output latch. A duty write (mode 0) gives no result;
// channels of CHANNELS or more are dropped. A tick (mode 1) is taken by the
// front end and yields eight results, MSB first, one per cycle from the
// serializer while out_pop is held; the 4-entry pattern queue absorbs
// bursts of up to four ticks ahead of the serializer. last marks bit 0,
// after which the external latch should update.
// period_top (reset 100) may be written only while the block is idle.
module multi_channel_pwm_serializer
  import mcps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire in_item_t   in_data,
  output logic            out_empty,
  input  wire logic       out_pop,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  q_status_t        q_stat;
  logic             q_push, q_pop, req_ready;
  logic [PAT_W-1:0] q_wr_data, q_rd_data;

  assign in_full = !req_ready;

  mcps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (in_push),
    .req       (in_data),
    .q_stat    (q_stat),
    .req_ready (req_ready),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  mcps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  mcps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
